FILE: rtl/dpr_pkg.sv
`timescale 1ns / 1ps

package dpr_pkg;

    // Decoded operator beat
    typedef struct packed {
        logic        [7:0]  cmd;
        logic signed [31:0] arg;
    } in_t;

    // Result beat
    typedef struct packed {
        logic signed [31:0] pos_h;
        logic signed [31:0] pos_v;
        logic signed [31:0] space_w;
        logic signed [31:0] space_x;
        logic signed [31:0] space_y;
        logic signed [31:0] space_z;
        logic        [5:0]  font_number;
        logic        [4:0]  depth;
        logic        [2:0]  status;
    } out_t;

    // One saved position set
    typedef struct packed {
        logic signed [31:0] h;
        logic signed [31:0] v;
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } tuple_t;

    // Shift control shared by every stack cell
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } cell_ctrl_t;

    // Opcodes
    localparam logic [7:0] OP_BOP     = 8'd139;
    localparam logic [7:0] OP_PUSH    = 8'd141;
    localparam logic [7:0] OP_POP     = 8'd142;
    localparam logic [7:0] OP_RIGHT1  = 8'd143;
    localparam logic [7:0] OP_RIGHT4  = 8'd146;
    localparam logic [7:0] OP_W0      = 8'd147;
    localparam logic [7:0] OP_W1      = 8'd148;
    localparam logic [7:0] OP_W4      = 8'd151;
    localparam logic [7:0] OP_X0      = 8'd152;
    localparam logic [7:0] OP_X1      = 8'd153;
    localparam logic [7:0] OP_X4      = 8'd156;
    localparam logic [7:0] OP_DOWN1   = 8'd157;
    localparam logic [7:0] OP_DOWN4   = 8'd160;
    localparam logic [7:0] OP_Y0      = 8'd161;
    localparam logic [7:0] OP_Y1      = 8'd162;
    localparam logic [7:0] OP_Y4      = 8'd165;
    localparam logic [7:0] OP_Z0      = 8'd166;
    localparam logic [7:0] OP_Z1      = 8'd167;
    localparam logic [7:0] OP_Z4      = 8'd170;
    localparam logic [7:0] OP_FNT_NUM_0  = 8'd171;
    localparam logic [7:0] OP_FNT_NUM_63 = 8'd234;
    localparam logic [7:0] OP_ILLEGAL_LO = 8'd250;

    // Status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW     = 3'd2;
    localparam logic [2:0] ST_ILLEGAL      = 3'd3;
    localparam logic [2:0] ST_BOP_NONEMPTY = 3'd4;

endpackage

FILE: rtl/dpr_stack_cell.sv
`timescale 1ns / 1ps

module dpr_stack_cell
(
    input  logic                clk,
    input  dpr_pkg::cell_ctrl_t ctrl,
    input  dpr_pkg::tuple_t     above,
    input  dpr_pkg::tuple_t     below,
    output dpr_pkg::tuple_t     q
);

    dpr_pkg::tuple_t data_reg;
    dpr_pkg::tuple_t data_next;

    // Push moves every entry one cell deeper; pop pulls every entry one cell up
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_en)
        begin
            data_next = above;
        end
        else if (ctrl.pop_en)
        begin
            data_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

FILE: rtl/dvi_position_register_machine.sv
`timescale 1ns / 1ps
// Each accepted operator's result beat is registered for the next cycle. One
// operator per cycle if out_ready allows; the saved-position stack is a row of
// cells that all shift together, so push and pop finish in the accepting cycle.
// Reset: h, v, w, x, y, z, font and stack depth clear to zero at once; stack
// cell contents are left undefined and are never read below the depth.

module dvi_position_register_machine
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dpr_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output dpr_pkg::out_t out_data
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    dpr_pkg::tuple_t    cur_reg;
    dpr_pkg::tuple_t    cur_next;
    logic [5:0]         font_reg;
    logic [5:0]         font_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    dpr_pkg::out_t      out_data_reg;
    dpr_pkg::out_t      out_data_next;

    logic [2:0]         status;
    logic               accept;
    logic [7:0]         font_diff;
    logic [CNT_W+4:0]   depth_ext;
    dpr_pkg::cell_ctrl_t ctrl;
    dpr_pkg::tuple_t    cell_q [STACK_DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cur_next     = cur_reg;
        font_next    = font_reg;
        count_next   = count_reg;
        status       = dpr_pkg::ST_OK;
        ctrl.push_en = 1'b0;
        ctrl.pop_en  = 1'b0;
        font_diff    = in_data.cmd - dpr_pkg::OP_FNT_NUM_0;

        if (in_data.cmd == dpr_pkg::OP_BOP)
        begin
            if (count_reg != '0)
            begin
                status = dpr_pkg::ST_BOP_NONEMPTY;
            end
            count_next = '0;
            cur_next   = '0;
        end
        else if (in_data.cmd == dpr_pkg::OP_PUSH)
        begin
            if (count_reg < CNT_W'(STACK_DEPTH))
            begin
                ctrl.push_en = 1'b1;
                count_next   = count_reg + CNT_W'(1);
            end
            else
            begin
                status = dpr_pkg::ST_OVERFLOW;
            end
        end
        else if (in_data.cmd == dpr_pkg::OP_POP)
        begin
            if (count_reg == '0)
            begin
                status = dpr_pkg::ST_UNDERFLOW;
            end
            else
            begin
                ctrl.pop_en = 1'b1;
                count_next  = count_reg - CNT_W'(1);
                cur_next    = cell_q[0];
            end
        end
        else if (in_data.cmd >= dpr_pkg::OP_RIGHT1 && in_data.cmd <= dpr_pkg::OP_RIGHT4)
        begin
            cur_next.h = cur_reg.h + in_data.arg;
        end
        else if (in_data.cmd == dpr_pkg::OP_W0)
        begin
            cur_next.h = cur_reg.h + cur_reg.w;
        end
        else if (in_data.cmd >= dpr_pkg::OP_W1 && in_data.cmd <= dpr_pkg::OP_W4)
        begin
            cur_next.w = in_data.arg;
            cur_next.h = cur_reg.h + in_data.arg;
        end
        else if (in_data.cmd == dpr_pkg::OP_X0)
        begin
            cur_next.h = cur_reg.h + cur_reg.x;
        end
        else if (in_data.cmd >= dpr_pkg::OP_X1 && in_data.cmd <= dpr_pkg::OP_X4)
        begin
            cur_next.x = in_data.arg;
            cur_next.h = cur_reg.h + in_data.arg;
        end
        else if (in_data.cmd >= dpr_pkg::OP_DOWN1 && in_data.cmd <= dpr_pkg::OP_DOWN4)
        begin
            cur_next.v = cur_reg.v + in_data.arg;
        end
        else if (in_data.cmd == dpr_pkg::OP_Y0)
        begin
            cur_next.v = cur_reg.v + cur_reg.y;
        end
        else if (in_data.cmd >= dpr_pkg::OP_Y1 && in_data.cmd <= dpr_pkg::OP_Y4)
        begin
            cur_next.y = in_data.arg;
            cur_next.v = cur_reg.v + in_data.arg;
        end
        else if (in_data.cmd == dpr_pkg::OP_Z0)
        begin
            cur_next.v = cur_reg.v + cur_reg.z;
        end
        else if (in_data.cmd >= dpr_pkg::OP_Z1 && in_data.cmd <= dpr_pkg::OP_Z4)
        begin
            cur_next.z = in_data.arg;
            cur_next.v = cur_reg.v + in_data.arg;
        end
        else if (in_data.cmd >= dpr_pkg::OP_FNT_NUM_0 &&
                 in_data.cmd <= dpr_pkg::OP_FNT_NUM_63)
        begin
            font_next = font_diff[5:0];
        end
        else if (in_data.cmd >= dpr_pkg::OP_ILLEGAL_LO)
        begin
            status = dpr_pkg::ST_ILLEGAL;
        end

        // Gate the stack shift controls with the handshake
        if (!accept)
        begin
            ctrl.push_en = 1'b0;
            ctrl.pop_en  = 1'b0;
        end
    end

    assign depth_ext = {5'b0, count_next};

    always_comb
    begin
        out_data_next.pos_h       = cur_next.h;
        out_data_next.pos_v       = cur_next.v;
        out_data_next.space_w     = cur_next.w;
        out_data_next.space_x     = cur_next.x;
        out_data_next.space_y     = cur_next.y;
        out_data_next.space_z     = cur_next.z;
        out_data_next.font_number = font_next;
        out_data_next.depth       = depth_ext[4:0];
        out_data_next.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            font_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_reg       <= cur_next;
                font_reg      <= font_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Stack: cell 0 holds the top entry
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        dpr_pkg::tuple_t above;
        dpr_pkg::tuple_t below;

        if (i == 0)
        begin : g_top
            assign above = cur_reg;
        end
        else
        begin : g_mid
            assign above = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_up
            assign below = cell_q[i+1];
        end

        dpr_stack_cell u_cell
        (
            .clk   (clk),
            .ctrl  (ctrl),
            .above (above),
            .below (below),
            .q     (cell_q[i])
        );
    end

endmodule
